@@ rtl/rdh_pkg.sv @@
// ----------------------------------------------------------------------------
// rdh_pkg
// Shared constants for the radial/depth histogram block.
// ----------------------------------------------------------------------------
package rdh_pkg;

  // default bin counts along each axis
  localparam int RadialBinsDefault = 256;
  localparam int DepthBinsDefault  = 256;

  // coordinate format: signed fixed point
  localparam int CoordWidth = 24;
  localparam int FracBits   = 8;

  // squared radius and its root
  localparam int SqWidth   = 2 * CoordWidth;
  localparam int RootWidth = CoordWidth;
  localparam int BinWidth  = RootWidth - FracBits;

  // histogram counts
  localparam int CountWidth = 32;
  localparam logic [CountWidth-1:0] CountMax = {1'b0, {(CountWidth-1){1'b1}}};
  localparam logic [CountWidth-1:0] CountMin = {1'b1, {(CountWidth-1){1'b0}}};

  // item kinds
  localparam logic KindRecord = 1'b0;
  localparam logic KindRead   = 1'b1;

endpackage

@@ rtl/rdh_ram.sv @@
// ----------------------------------------------------------------------------
// rdh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rdh_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/radial_depth_histogram.sv @@
// ----------------------------------------------------------------------------
// radial_depth_histogram
// Signed 2-D histogram over radial distance and depth with saturating counts.
// ----------------------------------------------------------------------------
// A read passes S_READ_WAIT and S_READ_OUT; a waiting result holds it back.
// A record works its end and, if due, its start position, each in S_SQX,
// S_SQY, S_SUM (square and sum), S_ROOT (bit-serial square root), S_CHECK
// and, if due, S_UPD_WAIT, S_UPD_WR (bin read-modify-write); one shared
// multiplier and one shared root step serve both positions.
// Throughput: one item at a time; in_ready is low while an item is worked.
// Reset: a clearing pass zeroes every bin, 2**(clog2(RADIAL_BINS) +
// clog2(DEPTH_BINS)) of them (65536 by default); no items are taken meanwhile.
// ----------------------------------------------------------------------------
module radial_depth_histogram #(
  parameter int RADIAL_BINS = rdh_pkg::RadialBinsDefault,
  parameter int DEPTH_BINS  = rdh_pkg::DepthBinsDefault
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 kind,
  input  logic signed [rdh_pkg::CoordWidth-1:0] end_x,
  input  logic signed [rdh_pkg::CoordWidth-1:0] end_y,
  input  logic signed [rdh_pkg::CoordWidth-1:0] end_z,
  input  logic signed [rdh_pkg::CoordWidth-1:0] start_x,
  input  logic signed [rdh_pkg::CoordWidth-1:0] start_y,
  input  logic signed [rdh_pkg::CoordWidth-1:0] start_z,
  input  logic                                 is_secondary,
  input  logic [7:0]                           read_radial_bin,
  input  logic [7:0]                           read_depth_bin,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rdh_pkg::CountWidth-1:0] bin_count
);

  localparam int CW = rdh_pkg::CoordWidth;
  localparam int FB = rdh_pkg::FracBits;
  localparam int SW = rdh_pkg::SqWidth;
  localparam int RW = rdh_pkg::RootWidth;
  localparam int BW = rdh_pkg::BinWidth;
  localparam int NW = rdh_pkg::CountWidth;

  // bin address = {radial index, depth index}
  localparam int RB = $clog2(RADIAL_BINS);
  localparam int DB = $clog2(DEPTH_BINS);
  localparam int AW = RB + DB;
  localparam int RamDepth = 2 ** AW;

  localparam int IterW = $clog2(RW);
  localparam logic [IterW-1:0] IterLast = IterW'(RW - 1);

  typedef enum logic [10:0] {
    S_CLEAR     = 11'b000_0000_0001,
    S_IDLE      = 11'b000_0000_0010,
    S_SQX       = 11'b000_0000_0100,
    S_SQY       = 11'b000_0000_1000,
    S_SUM       = 11'b000_0001_0000,
    S_ROOT      = 11'b000_0010_0000,
    S_CHECK     = 11'b000_0100_0000,
    S_UPD_WAIT  = 11'b000_1000_0000,
    S_UPD_WR    = 11'b001_0000_0000,
    S_READ_WAIT = 11'b010_0000_0000,
    S_READ_OUT  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  // held record
  logic signed [CW-1:0] ex, ey, ez, sx, sy, sz;
  logic                 sec;
  logic                 pt_start;   // 0: working on end position, 1: start
  logic                 upd_up;     // direction of the pending bin update
  logic                 rd_ok;      // read index in range

  // shared arithmetic
  logic [SW-1:0]    prod;
  logic [SW-1:0]    rad;
  logic [RW:0]      rem;
  logic [RW-1:0]    root;
  logic [IterW-1:0] iter;
  logic [AW-1:0]    clr_addr;

  // RAM port
  logic [AW-1:0]    raddr;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [NW-1:0]    ram_wdata;
  logic [NW-1:0]    ram_rdata;

  rdh_ram #(
    .Width (NW),
    .Depth (RamDepth)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Squaring operand: magnitude of x in S_SQX, of y otherwise, of the current
  // position. The magnitude of the most negative value fits unsigned.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] op_signed;
  logic [CW-1:0]        op_abs;
  logic [SW-1:0]        sq;

  always_comb begin
    if (state == S_SQX) begin
      op_signed = pt_start ? sx : ex;
    end else begin
      op_signed = pt_start ? sy : ey;
    end
    op_abs = op_signed[CW-1] ? (~op_signed + CW'(1)) : op_signed;
    sq     = SW'(op_abs) * SW'(op_abs);
  end

  // --------------------------------------------------------------------------
  // One restoring square-root step: bring down two radicand bits, try to
  // subtract {root, 01}, keep the remainder if it did not go negative.
  // --------------------------------------------------------------------------
  logic [RW+2:0] rem_try;
  logic [RW+3:0] rem_diff;
  logic          step_take;

  always_comb begin
    rem_try   = {rem, rad[SW-1 -: 2]};
    rem_diff  = {1'b0, rem_try} - {2'b00, root, 2'b01};
    step_take = !rem_diff[RW+3];
  end

  // --------------------------------------------------------------------------
  // Bin of the finished root and the current position's depth
  // --------------------------------------------------------------------------
  logic [BW-1:0]   pos_rbin;
  logic signed [CW-1:0] pos_z;
  logic [CW-2-FB:0] pos_zbin;
  logic            rbin_ok;
  logic            zbin_ok;
  logic            ez_pos;
  logic            end_used;
  logic            start_due;
  logic [AW-1:0]   pos_addr;

  always_comb begin
    pos_rbin  = root[RW-1:FB];
    pos_z     = pt_start ? sz : ez;
    pos_zbin  = pos_z[CW-2:FB];
    rbin_ok   = {{(32-BW){1'b0}}, pos_rbin} < RADIAL_BINS;
    zbin_ok   = {{(32-(CW-1-FB)){1'b0}}, pos_zbin} < DEPTH_BINS;
    ez_pos    = !ez[CW-1] && (|ez[CW-2:0]);
    // end depth zero or negative passes the depth range test
    end_used  = (ez_pos || sec) && rbin_ok && (ez[CW-1] || zbin_ok);
    start_due = sec && !sz[CW-1];
    pos_addr  = {RB'(pos_rbin), DB'(pos_zbin)};
  end

  // saturating update of the bin just read
  logic [NW-1:0] upd_value;

  always_comb begin
    if (upd_up) begin
      upd_value = (ram_rdata == rdh_pkg::CountMax) ? ram_rdata : ram_rdata + NW'(1);
    end else begin
      upd_value = (ram_rdata == rdh_pkg::CountMin) ? ram_rdata : ram_rdata - NW'(1);
    end
  end

  always_comb begin
    ram_we    = (state == S_CLEAR) || (state == S_UPD_WR);
    ram_waddr = (state == S_CLEAR) ? clr_addr : raddr;
    ram_wdata = (state == S_CLEAR) ? '0 : upd_value;
  end

  assign in_ready = (state == S_IDLE);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == {AW{1'b1}}) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = (kind == rdh_pkg::KindRead) ? S_READ_WAIT : S_SQX;
        end
      end
      S_SQX:  state_next = S_SQY;
      S_SQY:  state_next = S_SUM;
      S_SUM:  state_next = S_ROOT;
      S_ROOT: begin
        if (iter == IterLast) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!pt_start) begin
          if (!end_used)   state_next = S_IDLE;
          else if (ez_pos) state_next = S_UPD_WAIT;
          else             state_next = start_due ? S_SQX : S_IDLE;
        end else begin
          state_next = (rbin_ok && zbin_ok) ? S_UPD_WAIT : S_IDLE;
        end
      end
      S_UPD_WAIT: state_next = S_UPD_WR;
      S_UPD_WR: begin
        state_next = (!upd_up && start_due) ? S_SQX : S_IDLE;
      end
      S_READ_WAIT: state_next = S_READ_OUT;
      S_READ_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
      // load the result register when free, drop it on transfer
      if (state == S_READ_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ex       <= end_x;
          ey       <= end_y;
          ez       <= end_z;
          sx       <= start_x;
          sy       <= start_y;
          sz       <= start_z;
          sec      <= is_secondary;
          pt_start <= 1'b0;
          rd_ok    <= ({24'd0, read_radial_bin} < RADIAL_BINS) &&
                      ({24'd0, read_depth_bin} < DEPTH_BINS);
          raddr    <= {RB'(read_radial_bin), DB'(read_depth_bin)};
        end
      end
      S_SQX: prod <= sq;
      S_SQY: begin
        rad  <= prod;
        prod <= sq;
      end
      S_SUM: begin
        rad  <= rad + prod;
        rem  <= '0;
        root <= '0;
        iter <= '0;
      end
      S_ROOT: begin
        rad  <= {rad[SW-3:0], 2'b00};
        iter <= iter + IterW'(1);
        if (step_take) begin
          rem  <= rem_diff[RW:0];
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rem  <= rem_try[RW:0];
          root <= {root[RW-2:0], 1'b0};
        end
      end
      S_CHECK: begin
        raddr  <= pos_addr;
        upd_up <= pt_start;
        // no end update due: advance straight to the start position
        if (!pt_start && !ez_pos) pt_start <= 1'b1;
      end
      S_UPD_WR: begin
        pt_start <= 1'b1;
      end
      S_READ_OUT: begin
        if (out_free) bin_count <= rd_ok ? ram_rdata : '0;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_we_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_UPD_WR))
    else $error("histogram written outside clear or update");

  a_upd_addr: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD_WR) |-> ($past(state) == S_UPD_WAIT && $stable(raddr)))
    else $error("update write does not follow its read");

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ_OUT && $past(state) == S_READ_OUT) |-> $stable(raddr))
    else $error("read address moved while result waits");

  a_root_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> ($past(state) == S_ROOT && $past(iter) == IterLast))
    else $error("square root left before its last step");

endmodule
